// ----- sv/mbps_pkg.sv -----
// Shared constants, register codes and the result type of the masked byte
// pattern search. No dependencies.
package mbps_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int BYTE_W      = 8;
  localparam int OFF_W       = 48;
  localparam int LEN_W       = 4;
  localparam int SEEN_W      = $clog2(MAX_PATTERN + 1);
  localparam int SEL_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic MODE_DATA    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN = 3'd0,
    CFG_MASK    = 3'd1,
    CFG_LENGTH  = 3'd2,
    CFG_START   = 3'd3,
    CFG_END     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             matched;
    logic [OFF_W-1:0] first_offset;
    logic [OFF_W-1:0] last_offset;
    logic             finished;
  } res_t;

endpackage

// ----- sv/mbps_cell.sv -----
// One window cell: holds one stream byte, passes it to the next cell on each
// shift and compares the byte it takes in, masked, against its pattern byte.
// Depends on mbps_pkg.
module mbps_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       shift_en,
  input  logic                       active,
  input  logic [mbps_pkg::BYTE_W-1:0] byte_in,
  input  logic [mbps_pkg::BYTE_W-1:0] pat_byte,
  input  logic [mbps_pkg::BYTE_W-1:0] mask_byte,
  output logic [mbps_pkg::BYTE_W-1:0] byte_out,
  output logic                       hit
);
  import mbps_pkg::*;

  logic [BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      byte_r <= '0;
    end else if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign hit      = !active || ((byte_in & mask_byte) == pat_byte);

endmodule

// ----- sv/mbps_out_buf.sv -----
// Two-slot result buffer: a head register that drives the result channel and
// a skid slot behind it. Depends on mbps_pkg.
module mbps_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mbps_pkg::res_t      push_res,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output mbps_pkg::res_t      out_res
);
  import mbps_pkg::*;

  logic head_vld_r, head_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t head_r, head_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop = head_vld_r && out_ready;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        head_nxt = skid_r;
        if (push) begin
          skid_nxt = push_res;
        end else begin
          skid_vld_nxt = 1'b0;
        end
      end else if (push) begin
        head_nxt = push_res;
      end else begin
        head_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_vld_r) begin
        head_nxt     = push_res;
        head_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_res;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign can_push  = !skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_res   = head_r;

endmodule

// ----- sv/masked_byte_pattern_search.sv -----
// Top level of the masked byte pattern search: configuration registers,
// offset bookkeeping, the row of window cells and the result buffer.
// Depends on mbps_pkg, mbps_cell and mbps_out_buf.
//
// Usage: the input channel takes one item per cycle while in_ready is high:
// a data byte (in_mode = 0) or a restart (in_mode = 1), which clears the
// window, loads the offset from start_offset and reopens the search. A byte
// that completes a match of the last pattern_length bytes, or whose offset
// reaches end_offset, yields one result item; a restart with start_offset
// equal to end_offset yields a finished item at once. Other items yield
// nothing. Results are registered in the result buffer. Throughput: one
// item per cycle while in_ready is high, set by the shift and compare of
// the cell row. The output holds two results; while the receiver stalls,
// in_ready drops once both are full and rises again as soon as one is
// taken. Registers are written through the cfg_ channel, which is always
// ready. Reset (rst_n low, synchronous) clears the window, offset, done
// state and both result slots, and loads the registers' reset values.
module masked_byte_pattern_search (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [mbps_pkg::BYTE_W-1:0]     in_data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_matched,
  output logic [mbps_pkg::OFF_W-1:0]      out_first_offset,
  output logic [mbps_pkg::OFF_W-1:0]      out_last_offset,
  output logic                            out_finished
);
  import mbps_pkg::*;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] pattern_r;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] mask_r;
  logic [LEN_W-1:0]                   length_r;
  logic [OFF_W-1:0]                   start_r;
  logic [OFF_W-1:0]                   end_r;

  logic [OFF_W-1:0]  pos_r, pos_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic              done_r, done_nxt;

  logic              accept;
  logic              shift_en;
  logic              clear;
  logic [LEN_W-1:0]  used_len;
  logic              push;
  res_t              push_res;
  res_t              out_res;
  logic              can_push;
  logic              window_hit;
  logic              fin;

  logic [MAX_PATTERN-1:0]             cell_hit;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] cell_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      mask_r    <= '1;
      length_r  <= LEN_W'(1);
      start_r   <= '0;
      end_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PATTERN: pattern_r <= cfg_data;
        CFG_MASK:    mask_r    <= cfg_data;
        CFG_LENGTH:  length_r  <= cfg_data[LEN_W-1:0];
        CFG_START:   start_r   <= cfg_data[OFF_W-1:0];
        CFG_END:     end_r     <= cfg_data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (length_r == '0) begin
      used_len = LEN_W'(1);
    end else if (length_r > LEN_W'(MAX_PATTERN)) begin
      used_len = LEN_W'(MAX_PATTERN);
    end else begin
      used_len = length_r;
    end
  end

  assign in_ready = can_push;
  assign accept   = in_valid && in_ready;
  assign clear    = accept && (in_mode == MODE_RESTART);
  assign shift_en = accept && (in_mode == MODE_DATA) && !done_r;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEN_W-1:0]  diff;
    logic [SEL_W-1:0]  sel;
    logic [BYTE_W-1:0] byte_in;

    assign diff = used_len - LEN_W'(k + 1);
    assign sel  = diff[SEL_W-1:0];

    if (k == 0) begin : g_head
      assign byte_in = in_data_byte;
    end else begin : g_tail
      assign byte_in = cell_byte[k-1];
    end

    mbps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (clear),
      .shift_en  (shift_en),
      .active    (used_len > LEN_W'(k)),
      .byte_in   (byte_in),
      .pat_byte  (pattern_r[sel]),
      .mask_byte (mask_r[sel]),
      .byte_out  (cell_byte[k]),
      .hit       (cell_hit[k])
    );
  end

  always_comb begin
    seen_nxt = (seen_r < SEEN_W'(MAX_PATTERN)) ? seen_r + SEEN_W'(1) : seen_r;
  end

  assign window_hit = (&cell_hit) && (SEEN_W'(used_len) <= seen_nxt);
  assign fin        = pos_r >= end_r;

  always_comb begin
    pos_nxt  = pos_r;
    done_nxt = done_r;
    push     = 1'b0;
    push_res = '0;
    if (clear) begin
      pos_nxt  = start_r;
      done_nxt = (start_r == end_r);
      push     = (start_r == end_r);
      push_res.last_offset = start_r;
      push_res.finished    = 1'b1;
    end else if (shift_en) begin
      pos_nxt  = pos_r + OFF_W'(1);
      done_nxt = fin;
      push     = window_hit || fin;
      push_res.matched      = window_hit;
      push_res.first_offset = window_hit ?
                              (pos_r - OFF_W'(used_len) + OFF_W'(1)) : '0;
      push_res.last_offset  = pos_r;
      push_res.finished     = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      seen_r <= '0;
      done_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      done_r <= done_nxt;
      if (clear) begin
        seen_r <= '0;
      end else if (shift_en) begin
        seen_r <= seen_nxt;
      end
    end
  end

  mbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_matched      = out_res.matched;
  assign out_first_offset = out_res.first_offset;
  assign out_last_offset  = out_res.last_offset;
  assign out_finished     = out_res.finished;

endmodule
